@@ rtl/core/aes_pkg.sv @@
// aes_pkg: shared types, tables and round functions of the aes block cipher
// no dependencies; used by aes_block_cipher
package aes_pkg;

    localparam int KEY_WORDS_DEF = 4;
    localparam int ROUNDS_DEF    = 10;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPAND,
        S_FETCH,
        S_RUN,
        S_OUT
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0 = 3'd0,
        REG_KEY1 = 3'd1,
        REG_KEY2 = 3'd2,
        REG_KEY3 = 3'd3
    } t_cfg_reg;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int n = 0; n < 16; n++) begin
            t[127-8*n -: 8] = inv ? INV_SBOX[s[127-8*n -: 8]] : SBOX[s[127-8*n -: 8]];
        end
        return t;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        int src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
                t[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   a [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        logic [7:0]   m1 [4];
        logic [7:0]   m9 [4];
        logic [7:0]   mb [4];
        logic [7:0]   md [4];
        logic [7:0]   me [4];
        logic [7:0]   m3 [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]  = s[127-8*(4*c+k) -: 8];
                x2[k] = xtime(a[k]);
                x4[k] = xtime(x2[k]);
                x8[k] = xtime(x4[k]);
                m1[k] = a[k];
                m3[k] = x2[k] ^ a[k];
                m9[k] = x8[k] ^ a[k];
                mb[k] = x8[k] ^ x2[k] ^ a[k];
                md[k] = x8[k] ^ x4[k] ^ a[k];
                me[k] = x8[k] ^ x4[k] ^ x2[k];
            end
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    t[127-8*(4*c+r) -: 8] = me[r] ^ mb[(r+1)&3] ^ md[(r+2)&3] ^ m9[(r+3)&3];
                end else begin
                    t[127-8*(4*c+r) -: 8] = x2[r] ^ m3[(r+1)&3] ^ m1[(r+2)&3] ^ m1[(r+3)&3];
                end
            end
        end
        return t;
    endfunction

endpackage

@@ rtl/core/aes_block_cipher.sv @@
// aes_block_cipher: iterative aes encrypt / decrypt core with round key store
// depends on aes_pkg
//
// usage: key registers are written over the cfg channel (i_cfg_valid, o_cfg_ready,
// i_cfg_index, i_cfg_data) while the core is idle; o_cfg_ready is always high.
// an input beat (i_valid high, o_stall low) carries opcode and a 128-bit block.
// o_stall is high from the accepting edge until the result beat has been taken.
// the shared round unit runs one round per cycle: after accept a block passes the
// fetch state and the round states, then o_valid rises for the output beat.
// the first block after reset or a key write first expands the round keys,
// one 32-bit word per cycle, 4 * (ROUNDS + 1) words in all.
// round keys live in a one-port-write, one-port-read store with registered read.
// a new block is taken only once the previous result beat has been taken.
// the result is held stable while i_stall is high; no new block is taken then.
// reset (i_rst_n low, synchronous) clears the key registers and the expanded
// flag and returns the sequencer to idle.
module aes_block_cipher #(
    parameter int KEY_WORDS = aes_pkg::KEY_WORDS_DEF,
    parameter int ROUNDS    = aes_pkg::ROUNDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_opcode,
    input  logic [63:0]                    i_block_high,
    input  logic [63:0]                    i_block_low,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [63:0]                    o_result_high,
    output logic [63:0]                    o_result_low,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [aes_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]                    i_cfg_data
);
    import aes_pkg::*;

    localparam int STORE_WORDS = 4 * (ROUNDS + 1);
    localparam int WIW         = $clog2(STORE_WORDS);
    localparam int RW          = $clog2(ROUNDS + 1);
    localparam int KMW         = $clog2(KEY_WORDS);

    t_state          r_state, n_state;
    logic [63:0]     r_key [4];
    logic            r_kexp;
    logic [127:0]    r_mem [ROUNDS+1];
    logic [127:0]    r_rk;
    logic [127:0]    r_blk;
    logic            r_dec;
    logic [RW-1:0]   r_cnt;
    logic [WIW-1:0]  r_widx;
    logic [KMW-1:0]  r_kmod;
    logic [7:0]      r_rcon;
    logic [31:0]     r_win [KEY_WORDS];
    logic [95:0]     r_row;

    logic            w_in_acc;
    logic            w_out_acc;
    logic [31:0]     w_kw [8];
    logic [31:0]     w_prev;
    logic [31:0]     w_word;
    logic [RW-1:0]   w_cnt_nx;
    logic [RW-1:0]   w_step;
    logic [RW-1:0]   w_raddr;
    logic [127:0]    w_sb;
    logic [127:0]    w_sh;
    logic [127:0]    w_round;

    assign o_cfg_ready   = 1'b1;
    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_result_high = r_blk[127:64];
    assign o_result_low  = r_blk[63:0];
    assign w_in_acc      = i_valid && !o_stall;
    assign w_out_acc     = o_valid && !i_stall;

    // key schedule word generator
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_kw[2*k]   = r_key[k][63:32];
            w_kw[2*k+1] = r_key[k][31:0];
        end
        w_prev = r_win[KEY_WORDS-1];
        if (r_widx < WIW'(KEY_WORDS)) begin
            w_word = w_kw[r_widx[2:0]];
        end else if (r_kmod == '0) begin
            w_word = sub_word({w_prev[23:0], w_prev[31:24]}) ^ {r_rcon, 24'h0} ^ r_win[0];
        end else if ((KEY_WORDS > 6) && (r_kmod == KMW'(4))) begin
            w_word = sub_word(w_prev) ^ r_win[0];
        end else begin
            w_word = w_prev ^ r_win[0];
        end
    end

    // round unit
    always_comb begin
        w_cnt_nx = (r_cnt == RW'(ROUNDS)) ? r_cnt : r_cnt + RW'(1);
        w_step   = (r_state == S_RUN) ? w_cnt_nx : '0;
        w_raddr  = r_dec ? RW'(ROUNDS) - w_step : w_step;
        w_sb     = sub_bytes(r_dec ? shift_rows(r_blk, 1'b1) : r_blk, r_dec);
        w_sh     = r_dec ? w_sb : shift_rows(w_sb, 1'b0);
        if (r_cnt == '0) begin
            w_round = r_blk ^ r_rk;
        end else if (r_cnt == RW'(ROUNDS)) begin
            w_round = w_sh ^ r_rk;
        end else if (r_dec) begin
            w_round = mix_columns(w_sh ^ r_rk, 1'b1);
        end else begin
            w_round = mix_columns(w_sh, 1'b0) ^ r_rk;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = r_kexp ? S_FETCH : S_EXPAND;
                end
            end
            S_EXPAND: begin
                if (r_widx == WIW'(STORE_WORDS - 1)) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_RUN;
            S_RUN: begin
                if (r_cnt == RW'(ROUNDS)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_key[k] <= '0;
            end
            r_kexp <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_KEY0: begin r_key[0] <= i_cfg_data; r_kexp <= 1'b0; end
                REG_KEY1: begin r_key[1] <= i_cfg_data; r_kexp <= 1'b0; end
                REG_KEY2: begin r_key[2] <= i_cfg_data; r_kexp <= 1'b0; end
                REG_KEY3: begin r_key[3] <= i_cfg_data; r_kexp <= 1'b0; end
                default: ;
            endcase
        end else if ((r_state == S_EXPAND) && (r_widx == WIW'(STORE_WORDS - 1))) begin
            r_kexp <= 1'b1;
        end
    end

    // round key store
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EXPAND) && (r_widx[1:0] == 2'd3)) begin
            r_mem[r_widx[WIW-1:2]] <= {r_row, w_word};
        end
        r_rk <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_blk  <= {i_block_high, i_block_low};
            r_dec  <= i_opcode;
            r_widx <= '0;
            r_kmod <= '0;
            r_rcon <= 8'h01;
        end
        if (r_state == S_EXPAND) begin
            r_widx <= r_widx + WIW'(1);
            r_kmod <= (r_kmod == KMW'(KEY_WORDS - 1)) ? '0 : r_kmod + KMW'(1);
            if ((r_widx >= WIW'(KEY_WORDS)) && (r_kmod == '0)) begin
                r_rcon <= xtime(r_rcon);
            end
            for (int k = 0; k < KEY_WORDS - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[KEY_WORDS-1] <= w_word;
            r_row <= {r_row[63:0], w_word};
        end
        if (r_state == S_FETCH) begin
            r_cnt <= '0;
        end
        if (r_state == S_RUN) begin
            r_blk <= w_round;
            r_cnt <= w_cnt_nx;
        end
    end

    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_stall)
        else $error("input accepted without leaving idle");

    a_valid_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result shown while input side open");

    a_key_write_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && (i_cfg_index == REG_KEY0 || i_cfg_index == REG_KEY1
         || i_cfg_index == REG_KEY2 || i_cfg_index == REG_KEY3)) |=> !r_kexp)
        else $error("key write did not invalidate round keys");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt <= RW'(ROUNDS)))
        else $error("round counter out of range");

endmodule
